// File: hw/rtl/planar_pose_frame_transform_assert.svh
// Assertion macros shared by the frame transform RTL.
// Included by the files that check their own pipeline control; no other dependencies.
`ifndef PLANAR_POSE_FRAME_TRANSFORM_ASSERT_SVH
`define PLANAR_POSE_FRAME_TRANSFORM_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPFT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PPFT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/ppft_pkg.sv
// Shared types, constants and elaboration-time trig functions for the frame transform.
// No dependencies; used by ppft_trig_rom, ppft_rotate and planar_pose_frame_transform.
package ppft_pkg;

	localparam int COEF_W      = 16;
	localparam int TRIG_IDX_W  = 14;
	localparam int TRIG_DEPTH  = 8193;
	localparam int TRIG_HALF   = 8192;
	localparam int TRIG_QUART  = 16384;
	localparam int TRIG_QW     = 15;

	localparam int RND_SHIFT   = 15;
	localparam int RND_POS     = 16384;
	localparam int RND_NEG     = 16383;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;
	localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C235;

	typedef struct packed {
		logic [COEF_W-1:0] c;
		logic [COEF_W-1:0] s;
	} trig_pair_t;

	typedef struct packed {
		logic en_s3;
		logic en_s4;
	} ppft_stage_en_t;

	// (a*b) >> 62 for Q62 operands.
	function automatic logic [63:0] trig_mulq(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// round(32767 * v) for a Q62 value between zero and one.
	function automatic logic [COEF_W-1:0] trig_q15(input logic [63:0] v);
		logic [63:0] p;
		p = 64'd32767 * (v >> 15);
		return COEF_W'((p + (64'd1 << 46)) >> 47);
	endfunction

	// Cosine and sine in Q1.15 for an angle of 0 to 8192 binary-angle units,
	// from a thirteen-term series in Q62 integer arithmetic.
	function automatic trig_pair_t trig_base(input int unsigned t);
		logic [63:0] th;
		logic [63:0] th2;
		logic [63:0] st;
		logic [63:0] ss;
		logic [63:0] ct;
		logic [63:0] cs;
		trig_pair_t  res;
		th  = (PI_Q62 >> 15) * 64'(t);
		th2 = trig_mulq(th, th);
		st  = th;
		ss  = th;
		ct  = ONE_Q62;
		cs  = ONE_Q62;
		for (int k = 1; k <= 12; k++) begin
			st = trig_mulq(st, th2) / 64'((2 * k) * (2 * k + 1));
			ct = trig_mulq(ct, th2) / 64'((2 * k - 1) * (2 * k));
			if (k[0]) begin
				ss = ss - st;
				cs = cs - ct;
			end else begin
				ss = ss + st;
				cs = cs + ct;
			end
		end
		res.c = trig_q15(cs);
		res.s = trig_q15(ss);
		return res;
	endfunction

endpackage

// File: hw/rtl/ppft_trig_rom.sv
// Eighth-turn cosine/sine table with a registered read port.
// Depends on ppft_pkg for the entry type and the elaboration-time series.
module ppft_trig_rom (
	input  logic                             clk,
	input  logic                             en,
	input  logic [ppft_pkg::TRIG_IDX_W-1:0]  addr,
	output ppft_pkg::trig_pair_t             rd_data
);
	import ppft_pkg::*;

	trig_pair_t trig_tab [TRIG_DEPTH];
	trig_pair_t rd_data_q;

	for (genvar gi = 0; gi < TRIG_DEPTH; gi++) begin : g_tab
		localparam trig_pair_t ENTRY = trig_base(gi);
		assign trig_tab[gi] = ENTRY;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rd_data_q <= trig_tab[addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: hw/rtl/ppft_rotate.sv
// Two-stage rotation of a vector by a Q1.15 cosine/sine pair, with rounding and saturation.
// Depends on ppft_pkg for coefficient width, rounding constants and the stage enable struct.
module ppft_rotate #(
	parameter int IN_W  = 33,
	parameter int OUT_W = 32
) (
	input  logic                                clk,
	input  ppft_pkg::ppft_stage_en_t            en,
	input  logic signed [IN_W-1:0]              a,
	input  logic signed [IN_W-1:0]              b,
	input  logic signed [ppft_pkg::COEF_W-1:0]  cos_q,
	input  logic signed [ppft_pkg::COEF_W-1:0]  sin_q,
	output logic signed [OUT_W-1:0]             x,
	output logic signed [OUT_W-1:0]             y
);
	import ppft_pkg::*;

	localparam int PROD_W = IN_W + COEF_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam logic signed [SUM_W-1:0] SAT_MAX =
		{{(SUM_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_MIN =
		{{(SUM_W - OUT_W + 1){1'b1}}, {(OUT_W - 1){1'b0}}};

	logic signed [PROD_W-1:0] p_ac_s3, p_bs_s3, p_bc_s3, p_as_s3;
	logic signed [SUM_W-1:0]  sum_x_s4, sum_y_s4;
	logic signed [SUM_W-1:0]  rnd_x, rnd_y;

	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			p_ac_s3 <= PROD_W'(a) * PROD_W'(cos_q);
			p_bs_s3 <= PROD_W'(b) * PROD_W'(sin_q);
			p_bc_s3 <= PROD_W'(b) * PROD_W'(cos_q);
			p_as_s3 <= PROD_W'(a) * PROD_W'(sin_q);
		end
		if (en.en_s4) begin
			sum_x_s4 <= SUM_W'(p_ac_s3) + SUM_W'(p_bs_s3);
			sum_y_s4 <= SUM_W'(p_bc_s3) - SUM_W'(p_as_s3);
		end
	end

	// Round to nearest with ties away from zero: a negative sum takes one less
	// bias so that the arithmetic shift rounds its magnitude the same way.
	always_comb begin
		rnd_x = (sum_x_s4 + (sum_x_s4[SUM_W-1] ? SUM_W'(RND_NEG) : SUM_W'(RND_POS)))
			>>> RND_SHIFT;
		rnd_y = (sum_y_s4 + (sum_y_s4[SUM_W-1] ? SUM_W'(RND_NEG) : SUM_W'(RND_POS)))
			>>> RND_SHIFT;
		if (rnd_x > SAT_MAX) begin
			x = SAT_MAX[OUT_W-1:0];
		end else if (rnd_x < SAT_MIN) begin
			x = SAT_MIN[OUT_W-1:0];
		end else begin
			x = rnd_x[OUT_W-1:0];
		end
		if (rnd_y > SAT_MAX) begin
			y = SAT_MAX[OUT_W-1:0];
		end else if (rnd_y < SAT_MIN) begin
			y = SAT_MIN[OUT_W-1:0];
		end else begin
			y = rnd_y[OUT_W-1:0];
		end
	end

endmodule

// File: hw/rtl/planar_pose_frame_transform.sv
// Planar pose frame transform: each transfer moves an agent pose into the frame of a
// reference pose. The block accepts one transfer per clock unless the full pipeline
// waits on res_ready; the five register stages are the input register, the
// cosine/sine table read (8193 eighth-turn entries, registered), the multipliers, the
// cross-term adders and the output register with rounding and saturation. Every stage
// has its own valid bit and moves when the stage after it is empty or moving, so a
// result waiting on res_ready does not stop input until the whole pipeline is full.
// Depends on ppft_pkg, ppft_trig_rom, ppft_rotate and the assertion macro header.
`include "planar_pose_frame_transform_assert.svh"

module planar_pose_frame_transform (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [15:0] heading,
	input  logic signed [23:0] vel_x,
	input  logic signed [23:0] vel_y,
	input  logic        [2:0]  agent_class,
	input  logic               agent_valid,
	input  logic signed [31:0] ref_x,
	input  logic signed [31:0] ref_y,
	input  logic signed [15:0] ref_heading,
	output logic               res_valid,
	input  logic               res_ready,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic signed [16:0] out_heading,
	output logic signed [23:0] out_vel_x,
	output logic signed [23:0] out_vel_y,
	output logic        [2:0]  out_class,
	output logic               out_valid
);
	import ppft_pkg::*;

	// Stage valid bits and enables.
	logic valid_s1, valid_s2, valid_s3, valid_s4, res_valid_q;
	logic en_s1, en_s2, en_s3, en_s4, en_out;
	ppft_stage_en_t rot_en;

	// Stage 1: input register.
	logic signed [31:0] pos_x_s1, pos_y_s1, pos_z_s1, ref_x_s1, ref_y_s1;
	logic signed [15:0] heading_s1, ref_heading_s1;
	logic signed [23:0] vel_x_s1, vel_y_s1;
	logic        [2:0]  class_s1;
	logic               aval_s1;

	// Table index for the reference yaw.
	logic [TRIG_IDX_W-1:0] yaw_rem;
	logic                  swap_d;
	logic [TRIG_IDX_W-1:0] tab_idx;
	logic [TRIG_QW-1:0]    mirror;

	// Stage 2: differences and table data.
	logic signed [32:0] dx_s2, dy_s2;
	logic signed [23:0] vel_x_s2, vel_y_s2;
	logic signed [31:0] pos_z_s2;
	logic signed [16:0] hdiff_s2;
	logic        [2:0]  class_s2;
	logic               aval_s2;
	logic        [1:0]  quad_s2;
	logic               swap_s2;
	trig_pair_t         tab_s2;

	logic signed [COEF_W-1:0] base_c, base_s, cos_q, sin_q;

	// Stages 3 and 4 carry the pass-through fields next to the rotation units.
	logic signed [31:0] pos_z_s3, pos_z_s4;
	logic signed [16:0] hdiff_s3, hdiff_s4;
	logic        [2:0]  class_s3, class_s4;
	logic               aval_s3, aval_s4;

	logic signed [31:0] rot_x, rot_y;
	logic signed [23:0] rot_vx, rot_vy;

	// Output register.
	logic signed [31:0] out_x_q, out_y_q, out_z_q;
	logic signed [16:0] out_heading_q;
	logic signed [23:0] out_vel_x_q, out_vel_y_q;
	logic        [2:0]  out_class_q;
	logic               out_valid_q;

	assign en_out   = !res_valid_q || res_ready;
	assign en_s4    = !valid_s4 || en_out;
	assign en_s3    = !valid_s3 || en_s4;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;
	assign rot_en   = '{en_s3: en_s3, en_s4: en_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
			if (en_out) begin
				res_valid_q <= valid_s4;
			end
		end
	end

	// The table covers one eighth of a turn; the other eighth of each quadrant
	// reads the mirrored angle with cosine and sine swapped.
	always_comb begin
		yaw_rem = ref_heading_s1[TRIG_IDX_W-1:0];
		swap_d  = yaw_rem > TRIG_IDX_W'(TRIG_HALF);
		mirror  = TRIG_QW'(TRIG_QUART) - {1'b0, yaw_rem};
		tab_idx = swap_d ? mirror[TRIG_IDX_W-1:0] : yaw_rem;
	end

	ppft_trig_rom u_trig_rom (
		.clk     (clk),
		.en      (en_s2),
		.addr    (tab_idx),
		.rd_data (tab_s2)
	);

	always_comb begin
		base_c = swap_s2 ? signed'(tab_s2.s) : signed'(tab_s2.c);
		base_s = swap_s2 ? signed'(tab_s2.c) : signed'(tab_s2.s);
		case (quad_s2)
			QUAD_0: begin
				cos_q = base_c;
				sin_q = base_s;
			end
			QUAD_1: begin
				cos_q = -base_s;
				sin_q = base_c;
			end
			QUAD_2: begin
				cos_q = -base_c;
				sin_q = -base_s;
			end
			QUAD_3: begin
				cos_q = base_s;
				sin_q = -base_c;
			end
			default: begin
				cos_q = base_c;
				sin_q = base_s;
			end
		endcase
	end

	ppft_rotate #(
		.IN_W  (33),
		.OUT_W (32)
	) u_rot_pos (
		.clk   (clk),
		.en    (rot_en),
		.a     (dx_s2),
		.b     (dy_s2),
		.cos_q (cos_q),
		.sin_q (sin_q),
		.x     (rot_x),
		.y     (rot_y)
	);

	ppft_rotate #(
		.IN_W  (24),
		.OUT_W (24)
	) u_rot_vel (
		.clk   (clk),
		.en    (rot_en),
		.a     (vel_x_s2),
		.b     (vel_y_s2),
		.cos_q (cos_q),
		.sin_q (sin_q),
		.x     (rot_vx),
		.y     (rot_vy)
	);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			pos_x_s1       <= pos_x;
			pos_y_s1       <= pos_y;
			pos_z_s1       <= pos_z;
			heading_s1     <= heading;
			vel_x_s1       <= vel_x;
			vel_y_s1       <= vel_y;
			class_s1       <= agent_class;
			aval_s1        <= agent_valid;
			ref_x_s1       <= ref_x;
			ref_y_s1       <= ref_y;
			ref_heading_s1 <= ref_heading;
		end
		if (en_s2) begin
			dx_s2    <= 33'(pos_x_s1) - 33'(ref_x_s1);
			dy_s2    <= 33'(pos_y_s1) - 33'(ref_y_s1);
			vel_x_s2 <= vel_x_s1;
			vel_y_s2 <= vel_y_s1;
			pos_z_s2 <= pos_z_s1;
			hdiff_s2 <= 17'(heading_s1) - 17'(ref_heading_s1);
			class_s2 <= class_s1;
			aval_s2  <= aval_s1;
			quad_s2  <= ref_heading_s1[15:14];
			swap_s2  <= swap_d;
		end
		if (en_s3) begin
			pos_z_s3 <= pos_z_s2;
			hdiff_s3 <= hdiff_s2;
			class_s3 <= class_s2;
			aval_s3  <= aval_s2;
		end
		if (en_s4) begin
			pos_z_s4 <= pos_z_s3;
			hdiff_s4 <= hdiff_s3;
			class_s4 <= class_s3;
			aval_s4  <= aval_s3;
		end
		if (en_out) begin
			out_x_q       <= rot_x;
			out_y_q       <= rot_y;
			out_z_q       <= pos_z_s4;
			out_heading_q <= hdiff_s4;
			out_vel_x_q   <= rot_vx;
			out_vel_y_q   <= rot_vy;
			out_class_q   <= class_s4;
			out_valid_q   <= aval_s4;
		end
	end

	assign res_valid   = res_valid_q;
	assign out_x       = out_x_q;
	assign out_y       = out_y_q;
	assign out_z       = out_z_q;
	assign out_heading = out_heading_q;
	assign out_vel_x   = out_vel_x_q;
	assign out_vel_y   = out_vel_y_q;
	assign out_class   = out_class_q;
	assign out_valid   = out_valid_q;

	`PPFT_ASSERT_IMP(a_ready_when_drained, clk, arst_n, res_ready, in_ready, "input stalled while the output drains")
	`PPFT_ASSERT_IMP(a_no_overrun, clk, arst_n, res_valid && !res_ready && valid_s1 && valid_s2 && valid_s3 && valid_s4, !in_ready, "input taken into a full pipeline")
	`PPFT_ASSERT_NXT(a_accept_lands, clk, arst_n, in_valid && in_ready, valid_s1, "accepted transfer missing from stage one")
	`PPFT_ASSERT_NXT(a_last_stage_moves, clk, arst_n, valid_s4 && en_out, res_valid, "result lost between stage four and the output")

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench for planar_pose_frame_transform: drives agent and reference poses with random
// idle gaps on one or both handshakes in all but the full-rate test, and checks every result
// against a bit-exact local predictor. Depends on the RTL of the block and on ppft_pkg for the quadrant codes.
module tb_top;

	import ppft_pkg::QUAD_0;
	import ppft_pkg::QUAD_1;
	import ppft_pkg::QUAD_2;
	import ppft_pkg::QUAD_3;

	localparam int unsigned CYCLE_LIMIT   = 300000;
	localparam int unsigned DRAIN_CYCLES  = 12;
	localparam int unsigned MAX_IDLE      = 8;
	localparam int unsigned EIGHTH_TURN   = 8192;
	localparam int unsigned QUARTER_TURN  = 16384;
	localparam logic [63:0] UNIT_Q62      = 64'h4000000000000000;
	localparam logic [63:0] HALF_TURN_Q62 = 64'hC90FDAA22168C235;
	localparam int          POS_MAX       = 32'sh7FFFFFFF;
	localparam int          POS_MIN       = 32'sh80000000;
	localparam int          VEL_MAX       = 8388607;
	localparam int          VEL_MIN       = -8388608;

	typedef struct {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] heading;
		logic signed [23:0] vel_x;
		logic signed [23:0] vel_y;
		logic        [2:0]  agent_class;
		logic               agent_valid;
		logic signed [31:0] ref_x;
		logic signed [31:0] ref_y;
		logic signed [15:0] ref_heading;
	} agent_pose_t;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [16:0] heading;
		logic signed [23:0] vel_x;
		logic signed [23:0] vel_y;
		logic        [2:0]  agent_class;
		logic               valid;
	} local_pose_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [31:0] pos_x = '0;
	logic signed [31:0] pos_y = '0;
	logic signed [31:0] pos_z = '0;
	logic signed [15:0] heading = '0;
	logic signed [23:0] vel_x = '0;
	logic signed [23:0] vel_y = '0;
	logic        [2:0]  agent_class = '0;
	logic               agent_valid = 1'b0;
	logic signed [31:0] ref_x = '0;
	logic signed [31:0] ref_y = '0;
	logic signed [15:0] ref_heading = '0;
	logic               res_valid;
	logic               res_ready = 1'b1;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic signed [16:0] out_heading;
	logic signed [23:0] out_vel_x;
	logic signed [23:0] out_vel_y;
	logic        [2:0]  out_class;
	logic               out_valid;

	local_pose_t poses_in_flight[$];
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	bit          src_idle = 1'b1;
	bit          sink_idle = 1'b1;

	planar_pose_frame_transform DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.heading     (heading),
		.vel_x       (vel_x),
		.vel_y       (vel_y),
		.agent_class (agent_class),
		.agent_valid (agent_valid),
		.ref_x       (ref_x),
		.ref_y       (ref_y),
		.ref_heading (ref_heading),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_z       (out_z),
		.out_heading (out_heading),
		.out_vel_x   (out_vel_x),
		.out_vel_y   (out_vel_y),
		.out_class   (out_class),
		.out_valid   (out_valid)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 0;
	end

	// Product of two Q62 values, kept in Q62.
	function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] wide;
		wide = 128'(a) * 128'(b);
		return wide[125:62];
	endfunction

	function automatic int q62_to_q15(input logic [63:0] v);
		logic [63:0] scaled;
		scaled = 64'd32767 * (v >> 15);
		return int'((scaled + (64'd1 << 46)) >> 47);
	endfunction

	// Taylor series for an angle within the first eighth of a turn.
	function automatic void eighth_turn_cos_sin(input int unsigned t, output int c, output int s);
		logic [63:0] theta;
		logic [63:0] theta_sq;
		logic [63:0] sin_term;
		logic [63:0] sin_sum;
		logic [63:0] cos_term;
		logic [63:0] cos_sum;
		int          k;
		theta    = (HALF_TURN_Q62 >> 15) * 64'(t);
		theta_sq = q62_product(theta, theta);
		sin_term = theta;
		sin_sum  = theta;
		cos_term = UNIT_Q62;
		cos_sum  = UNIT_Q62;
		for (k = 1; k <= 12; k++) begin
			sin_term = q62_product(sin_term, theta_sq) / 64'((2 * k) * (2 * k + 1));
			cos_term = q62_product(cos_term, theta_sq) / 64'((2 * k - 1) * (2 * k));
			if (k % 2 == 1) begin
				sin_sum = sin_sum - sin_term;
				cos_sum = cos_sum - cos_term;
			end else begin
				sin_sum = sin_sum + sin_term;
				cos_sum = cos_sum + cos_term;
			end
		end
		c = q62_to_q15(cos_sum);
		s = q62_to_q15(sin_sum);
	endfunction

	function automatic void heading_cos_sin(input logic [15:0] angle, output int c, output int s);
		logic [1:0]  quad;
		int unsigned rem;
		int          oc;
		int          os;
		quad = angle[15:14];
		rem  = angle[13:0];
		// Past the eighth turn, fold onto the complementary angle with cos and sin swapped.
		if (rem <= EIGHTH_TURN) begin
			eighth_turn_cos_sin(rem, oc, os);
		end else begin
			eighth_turn_cos_sin(QUARTER_TURN - rem, os, oc);
		end
		case (quad)
			QUAD_0: begin c = oc;  s = os;  end
			QUAD_1: begin c = -os; s = oc;  end
			QUAD_2: begin c = -oc; s = -os; end
			QUAD_3: begin c = os;  s = -oc; end
			default: begin c = oc; s = os; end
		endcase
	endfunction

	// Divide by 2^15, rounding to nearest with ties away from zero.
	function automatic longint round_q15(input longint v);
		if (v < 0) begin
			return -((-v + 64'sd16384) >>> 15);
		end
		return (v + 64'sd16384) >>> 15;
	endfunction

	function automatic longint clamp_signed(input longint v, input int unsigned w);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		return (v > hi) ? hi : ((v < lo) ? lo : v);
	endfunction

	function automatic local_pose_t to_reference_frame(input agent_pose_t p);
		local_pose_t r;
		int          c;
		int          s;
		longint      dx;
		longint      dy;
		longint      vx;
		longint      vy;
		heading_cos_sin(p.ref_heading, c, s);
		dx = longint'(p.pos_x) - longint'(p.ref_x);
		dy = longint'(p.pos_y) - longint'(p.ref_y);
		vx = longint'(p.vel_x);
		vy = longint'(p.vel_y);
		r.x           = 32'(clamp_signed(round_q15(dx * c + dy * s), 32));
		r.y           = 32'(clamp_signed(round_q15(dy * c - dx * s), 32));
		r.z           = p.pos_z;
		r.heading     = 17'(longint'(p.heading) - longint'(p.ref_heading));
		r.vel_x       = 24'(clamp_signed(round_q15(vx * c + vy * s), 24));
		r.vel_y       = 24'(clamp_signed(round_q15(vy * c - vx * s), 24));
		r.agent_class = p.agent_class;
		r.valid       = p.agent_valid;
		return r;
	endfunction

	function automatic agent_pose_t make_pose(input int px, input int py, input int pz,
			input int hd, input int vx, input int vy, input int cls, input int vld,
			input int rx, input int ry, input int rh);
		agent_pose_t p;
		p.pos_x       = px;
		p.pos_y       = py;
		p.pos_z       = pz;
		p.heading     = 16'(hd);
		p.vel_x       = 24'(vx);
		p.vel_y       = 24'(vy);
		p.agent_class = 3'(cls);
		p.agent_valid = 1'(vld);
		p.ref_x       = rx;
		p.ref_y       = ry;
		p.ref_heading = 16'(rh);
		return p;
	endfunction

	// Mostly uniform, with the range ends and the values around zero mixed in.
	function automatic int wide_value();
		case ($urandom_range(0, 15))
			0: return POS_MAX;
			1: return POS_MIN;
			2: return 0;
			3: return -1;
			default: return int'($urandom);
		endcase
	endfunction

	function automatic agent_pose_t random_pose(input bit near_ref);
		agent_pose_t p;
		p.pos_z       = $urandom;
		p.heading     = 16'($urandom);
		p.agent_class = 3'($urandom_range(0, 7));
		p.agent_valid = 1'($urandom_range(0, 1));
		p.ref_heading = 16'($urandom);
		if (near_ref) begin
			// Typical traffic: agents within 2^20 units of the reference pose on each axis.
			p.ref_x = $urandom;
			p.ref_y = $urandom;
			p.pos_x = p.ref_x + 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
			p.pos_y = p.ref_y + 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
			p.vel_x = 24'($signed(16'($urandom)));
			p.vel_y = 24'($signed(16'($urandom)));
		end else begin
			p.ref_x = wide_value();
			p.ref_y = wide_value();
			p.pos_x = wide_value();
			p.pos_y = wide_value();
			p.vel_x = 24'(wide_value());
			p.vel_y = 24'(wide_value());
		end
		return p;
	endfunction

	task automatic send_pose(input agent_pose_t p);
		int unsigned gap;
		gap = src_idle ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pos_x       <= p.pos_x;
		pos_y       <= p.pos_y;
		pos_z       <= p.pos_z;
		heading     <= p.heading;
		vel_x       <= p.vel_x;
		vel_y       <= p.vel_y;
		agent_class <= p.agent_class;
		agent_valid <= p.agent_valid;
		ref_x       <= p.ref_x;
		ref_y       <= p.ref_y;
		ref_heading <= p.ref_heading;
		in_valid    <= 1'b1;
		do @(posedge clk); while (!in_ready);
		poses_in_flight.insert(poses_in_flight.size(), to_reference_frame(p));
	endtask

	task automatic test_corner_cases();
		src_idle  = 1'b1;
		sink_idle = 1'b1;
		send_pose(make_pose(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// Position differences beyond the 32-bit range must saturate.
		send_pose(make_pose(POS_MAX, POS_MAX, POS_MAX, 0, 0, 0, 1, 1, POS_MIN, POS_MIN, 0));
		send_pose(make_pose(POS_MIN, POS_MIN, POS_MIN, 0, 0, 0, 2, 1, POS_MAX, POS_MAX, 0));
		send_pose(make_pose(POS_MAX, POS_MIN, -1, 100, 0, 0, 3, 0,
			POS_MIN, POS_MAX, -32768));
		send_pose(make_pose(POS_MAX, POS_MAX, 5, 0, 0, 0, 4, 1, POS_MIN, POS_MIN, 8192));
		// Heading differences at both ends of the unwrapped range.
		send_pose(make_pose(1024, -1024, 7, -32768, 1000, -1000, 5, 1, 0, 0, 32767));
		send_pose(make_pose(-1024, 1024, 9, 32767, -1000, 1000, 0, 0, 0, 0, -32768));
		// Rotated velocity beyond the 24-bit range must saturate.
		send_pose(make_pose(0, 0, 0, 0, VEL_MAX, VEL_MAX, 1, 1, 0, 0, 8192));
		send_pose(make_pose(0, 0, 0, 0, VEL_MIN, VEL_MIN, 2, 1, 0, 0, 8192));
		send_pose(make_pose(0, 0, 0, 0, VEL_MAX, VEL_MIN, 3, 1, 0, 0, -8192));
		send_pose(make_pose(0, 0, 0, 0, VEL_MIN, VEL_MAX, 4, 0, 0, 0, 24576));
		// Angles on both sides of the eighth-turn fold and at the quadrant boundaries.
		send_pose(make_pose(300000, -200000, 0, 1, 50000, 70000, 5, 1, 1000, 2000, 8193));
		send_pose(make_pose(300000, -200000, 0, 2, 50000, 70000, 0, 1, 1000, 2000, 16383));
		send_pose(make_pose(300000, -200000, 0, 3, 50000, 70000, 1, 1, 1000, 2000, 16384));
		send_pose(make_pose(300000, -200000, 0, 4, 50000, 70000, 2, 1, 1000, 2000, -16384));
		send_pose(make_pose(300000, -200000, 0, 5, 50000, 70000, 3, 1, 1000, 2000, 1));
		send_pose(make_pose(300000, -200000, 0, 6, 50000, 70000, 4, 1, 1000, 2000, -1));
		// Class codes 6 and 7 pass through as they are.
		send_pose(make_pose(-5, 5, POS_MIN, -1, -1, 1, 6, 1, 5, -5, 12345));
		send_pose(make_pose(5, -5, POS_MAX, 1, 1, -1, 7, 0, -5, 5, -12345));
	endtask

	task automatic test_wide_range(input int unsigned count);
		src_idle  = 1'b1;
		sink_idle = 1'b1;
		repeat (count) send_pose(random_pose(1'b0));
	endtask

	task automatic test_local_frames(input int unsigned count);
		src_idle  = 1'b1;
		sink_idle = 1'b1;
		repeat (count) send_pose(random_pose(1'b1));
	endtask

	task automatic test_full_rate(input int unsigned count);
		src_idle  = 1'b0;
		sink_idle = 1'b0;
		repeat (count) send_pose(random_pose(1'($urandom_range(0, 1))));
	endtask

	task automatic test_output_stalls(input int unsigned count);
		src_idle  = 1'b0;
		sink_idle = 1'b1;
		repeat (count) send_pose(random_pose(1'($urandom_range(0, 1))));
	endtask

	// Result side: while sink_idle is set, stall for a random number of cycles before each transfer.
	initial begin
		int unsigned stall;
		forever begin
			stall = sink_idle ? $urandom_range(0, MAX_IDLE) : 0;
			if (stall != 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(posedge clk);
				res_ready <= 1'b1;
			end
			do @(posedge clk); while (!(arst_n && res_valid));
		end
	end

	always @(posedge clk) begin
		local_pose_t exp_pose;
		if (arst_n && res_valid && res_ready) begin
			if (poses_in_flight.size() == 0) begin
				$error("result transfer with no pose outstanding");
				error_count++;
			end else begin
				exp_pose = poses_in_flight.pop_front();
				if (out_x !== exp_pose.x) begin
					$error("out_x: expected %0d, actual %0d", exp_pose.x, out_x);
					error_count++;
				end
				if (out_y !== exp_pose.y) begin
					$error("out_y: expected %0d, actual %0d", exp_pose.y, out_y);
					error_count++;
				end
				if (out_z !== exp_pose.z) begin
					$error("out_z: expected %0d, actual %0d", exp_pose.z, out_z);
					error_count++;
				end
				if (out_heading !== exp_pose.heading) begin
					$error("out_heading: expected %0d, actual %0d", exp_pose.heading,
						out_heading);
					error_count++;
				end
				if (out_vel_x !== exp_pose.vel_x) begin
					$error("out_vel_x: expected %0d, actual %0d", exp_pose.vel_x, out_vel_x);
					error_count++;
				end
				if (out_vel_y !== exp_pose.vel_y) begin
					$error("out_vel_y: expected %0d, actual %0d", exp_pose.vel_y, out_vel_y);
					error_count++;
				end
				if (out_class !== exp_pose.agent_class) begin
					$error("out_class: expected %0d, actual %0d", exp_pose.agent_class,
						out_class);
					error_count++;
				end
				if (out_valid !== exp_pose.valid) begin
					$error("out_valid: expected %0d, actual %0d", exp_pose.valid, out_valid);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_cases();
		test_wide_range(300);
		test_local_frames(300);
		test_full_rate(100);
		test_output_stalls(100);
		in_valid <= 1'b0;
		while (poses_in_flight.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/ppft_pkg.sv
hw/rtl/ppft_trig_rom.sv
hw/rtl/ppft_rotate.sv
hw/rtl/planar_pose_frame_transform.sv
bench/tb_top.sv
